### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the core design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside of reset.
`define SRDC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the first condition holds, the second holds in the next cycle.
`define SRDC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### design/srdc_pkg.sv
// ----------------------------------------------------------------------------
// srdc_pkg
// Widths, register addresses, query codes and controller states of the
// signed-rank distribution counter.
// ----------------------------------------------------------------------------
package srdc_pkg;

    localparam int unsigned MAX_SAMPLE  = 32;
    localparam int unsigned TABLE_DEPTH = 265;

    localparam int unsigned SAMPLE_W = 6;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned RANK_W   = 10;
    localparam int unsigned COUNT_W  = 33;

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
    localparam int unsigned TBL_W  = MAX_SAMPLE;
    localparam int unsigned ACC_W  = MAX_SAMPLE + 1;
    localparam int unsigned CMP_W  = (ACC_W > COUNT_W) ? ACC_W : COUNT_W;
    localparam int unsigned NE_W   = $clog2(MAX_SAMPLE + 1);
    localparam int unsigned J_W    = $clog2(MAX_SAMPLE + 2);

    localparam int unsigned UT_W = $clog2(MAX_SAMPLE * (MAX_SAMPLE + 1) + MAX_SAMPLE + 2);
    localparam int unsigned UA_W = (UT_W > ADDR_W) ? UT_W : ADDR_W;
    localparam int unsigned UW   = (UA_W > RANK_W) ? UA_W : RANK_W;

    localparam int unsigned PADDR_W = 2;
    localparam int unsigned PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_SAMPLE_SIZE = PADDR_W'(0);

    localparam logic [MODE_W-1:0] MODE_DENSITY  = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_CUMUL    = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_QUANTILE = MODE_W'(2);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_BUILD_J,
        ST_BUILD_RD_HI,
        ST_BUILD_RD_LO,
        ST_BUILD_WR,
        ST_START,
        ST_WALK,
        ST_OUT
    } t_state;

endpackage

### design/srdc_ram.sv
// ----------------------------------------------------------------------------
// srdc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srdc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/signed_rank_distribution_counter_core.sv
// ----------------------------------------------------------------------------
// signed_rank_distribution_counter_core
// Exact signed-rank distribution counts for a configurable sample size.
// ----------------------------------------------------------------------------
// Usage: write the sample size n over the APB port at address 0 while the
// block is idle. Query items arrive on the input channel (mode, rank sum,
// threshold) and each item gives exactly one result item (count, quantile)
// on the output channel. Counts are probabilities scaled by 2^n.
// The first item after reset or after a write to the sample size first
// builds the count table in the RAM: a clear pass over the used entries and
// then the knapsack updates, each a read state and then a write state.
// After that, a density item reads a single entry, a cumulative item walks
// the entries from 0 up to the rank sum, and a quantile item walks up to the
// found quantile; the single RAM read port reads one entry per cycle.
// One item is worked on at a time. A finished result sits in the output
// register, and the next item is taken while the receiver stalls it.
// Reset sets the sample size to 1 and marks the table as not built.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_rank_distribution_counter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srdc_pkg::PADDR_W-1:0]    paddr,
    input  logic [srdc_pkg::PDATA_W-1:0]    pwdata,
    output logic [srdc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [srdc_pkg::MODE_W-1:0]     i_mode,
    input  logic [srdc_pkg::RANK_W-1:0]     i_rank_sum,
    input  logic [srdc_pkg::COUNT_W-1:0]    i_threshold,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [srdc_pkg::COUNT_W-1:0]    o_count,
    output logic [srdc_pkg::RANK_W-1:0]     o_quantile
);

    localparam int unsigned UW      = srdc_pkg::UW;
    localparam int unsigned ADDR_W  = srdc_pkg::ADDR_W;
    localparam int unsigned TBL_W   = srdc_pkg::TBL_W;
    localparam int unsigned ACC_W   = srdc_pkg::ACC_W;
    localparam int unsigned CMP_W   = srdc_pkg::CMP_W;
    localparam int unsigned COUNT_W = srdc_pkg::COUNT_W;
    localparam int unsigned RANK_W  = srdc_pkg::RANK_W;
    localparam int unsigned NE_W    = srdc_pkg::NE_W;
    localparam int unsigned J_W     = srdc_pkg::J_W;

    srdc_pkg::t_state r_state, n_state;

    logic [srdc_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic                          r_tbl_ready, n_tbl_ready;
    logic [srdc_pkg::MODE_W-1:0]   r_mode, n_mode;
    logic [RANK_W-1:0]             r_rank, n_rank;
    logic [COUNT_W-1:0]            r_thr, n_thr;
    logic [ADDR_W-1:0]             r_i, n_i;
    logic [J_W-1:0]                r_j, n_j;
    logic [UW-1:0]                 r_tri, n_tri;
    logic [TBL_W-1:0]              r_hi, n_hi;
    logic [UW-1:0]                 r_k, n_k;
    logic                          r_dv, n_dv;
    logic [UW-1:0]                 r_kd, n_kd;
    logic                          r_zd, n_zd;
    logic [ACC_W-1:0]              r_acc, n_acc;
    logic [COUNT_W-1:0]            r_res_count, n_res_count;
    logic [RANK_W-1:0]             r_res_q, n_res_q;
    logic                          r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]            r_count, n_count;
    logic [RANK_W-1:0]             r_quantile, n_quantile;

    logic              cfg_we;
    logic              in_accept;
    logic              out_free;
    logic [NE_W-1:0]   eff_n;
    logic [UW-1:0]     u_prod;
    logic [UW-1:0]     u;
    logic [UW-1:0]     c;
    logic [UW-1:0]     lim;
    logic [ACC_W-1:0]  full;
    logic [UW-1:0]     j_ext;
    logic [UW-1:0]     b_end;
    logic [UW-1:0]     k_fold;
    logic              k_zero;
    logic [ADDR_W-1:0] k_addr;
    logic [ACC_W-1:0]  acc_sum;
    logic              walk_done;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [TBL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [TBL_W-1:0]  ram_rdata;

    srdc_ram #(
        .WIDTH (TBL_W),
        .DEPTH (srdc_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite && (paddr == srdc_pkg::REG_SAMPLE_SIZE);
    assign prdata    = (paddr == srdc_pkg::REG_SAMPLE_SIZE) ?
                       srdc_pkg::PDATA_W'(r_sample) : '0;
    assign o_in_stall = (r_state != srdc_pkg::ST_IDLE);
    assign in_accept  = i_in_valid && (r_state == srdc_pkg::ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_count     = r_count;
    assign o_quantile  = r_quantile;

    always_comb begin
        if (r_sample == '0) begin
            eff_n = NE_W'(1);
        end else if (32'(r_sample) > srdc_pkg::MAX_SAMPLE) begin
            eff_n = NE_W'(srdc_pkg::MAX_SAMPLE);
        end else begin
            eff_n = NE_W'(r_sample);
        end
    end

    assign u_prod = UW'(eff_n) * (UW'(eff_n) + UW'(1));
    assign u      = u_prod >> 1;
    assign c      = u >> 1;
    assign lim    = (c < UW'(srdc_pkg::TABLE_DEPTH - 1)) ? c : UW'(srdc_pkg::TABLE_DEPTH - 1);
    assign full   = ACC_W'(1) << eff_n;
    assign j_ext  = UW'(r_j);
    assign b_end  = (r_tri < lim) ? r_tri : lim;

    // Rank sums above the midpoint read their mirror entry.
    assign k_fold = (r_k > c) ? (u - r_k) : r_k;
    assign k_zero = (r_k > u) || (k_fold >= UW'(srdc_pkg::TABLE_DEPTH));
    assign k_addr = ADDR_W'(k_fold);

    assign acc_sum = r_acc + (r_zd ? '0 : ACC_W'(ram_rdata));

    always_comb begin
        case (r_mode)
            srdc_pkg::MODE_DENSITY:  walk_done = r_dv;
            srdc_pkg::MODE_CUMUL:    walk_done = r_dv && (r_kd == UW'(r_rank));
            srdc_pkg::MODE_QUANTILE: walk_done = r_dv &&
                ((CMP_W'(acc_sum) >= CMP_W'(r_thr)) || (r_kd == u));
            default:                 walk_done = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            srdc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = r_tbl_ready ? srdc_pkg::ST_START : srdc_pkg::ST_CLEAR;
                end
            end
            srdc_pkg::ST_CLEAR: begin
                if (UW'(r_i) == lim) begin
                    n_state = srdc_pkg::ST_BUILD_J;
                end
            end
            srdc_pkg::ST_BUILD_J: begin
                if (j_ext > UW'(eff_n)) begin
                    n_state = srdc_pkg::ST_START;
                end else if (b_end >= j_ext) begin
                    n_state = srdc_pkg::ST_BUILD_RD_HI;
                end
            end
            srdc_pkg::ST_BUILD_RD_HI: n_state = srdc_pkg::ST_BUILD_RD_LO;
            srdc_pkg::ST_BUILD_RD_LO: n_state = srdc_pkg::ST_BUILD_WR;
            srdc_pkg::ST_BUILD_WR: begin
                n_state = (UW'(r_i) == j_ext) ? srdc_pkg::ST_BUILD_J : srdc_pkg::ST_BUILD_RD_LO;
            end
            srdc_pkg::ST_START: begin
                case (r_mode)
                    srdc_pkg::MODE_DENSITY: n_state = srdc_pkg::ST_WALK;
                    srdc_pkg::MODE_CUMUL: begin
                        n_state = (UW'(r_rank) >= u) ? srdc_pkg::ST_OUT : srdc_pkg::ST_WALK;
                    end
                    srdc_pkg::MODE_QUANTILE: begin
                        n_state = (CMP_W'(r_thr) > CMP_W'(full)) ?
                                  srdc_pkg::ST_OUT : srdc_pkg::ST_WALK;
                    end
                    default: n_state = srdc_pkg::ST_OUT;
                endcase
            end
            srdc_pkg::ST_WALK: begin
                if (walk_done) begin
                    n_state = srdc_pkg::ST_OUT;
                end
            end
            srdc_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = srdc_pkg::ST_IDLE;
                end
            end
            default: n_state = srdc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_sample    = r_sample;
        n_tbl_ready = r_tbl_ready;
        n_mode      = r_mode;
        n_rank      = r_rank;
        n_thr       = r_thr;
        n_i         = r_i;
        n_j         = r_j;
        n_tri       = r_tri;
        n_hi        = r_hi;
        n_k         = r_k;
        n_dv        = r_dv;
        n_kd        = r_kd;
        n_zd        = r_zd;
        n_acc       = r_acc;
        n_res_count = r_res_count;
        n_res_q     = r_res_q;
        n_out_valid = r_out_valid && i_out_stall;
        n_count     = r_count;
        n_quantile  = r_quantile;
        ram_we      = 1'b0;
        ram_waddr   = r_i;
        ram_wdata   = '0;
        ram_raddr   = k_addr;

        case (r_state)
            srdc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_mode = i_mode;
                    n_rank = i_rank_sum;
                    n_thr  = i_threshold;
                    n_i    = '0;
                end
            end
            srdc_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = (r_i <= ADDR_W'(1)) ? TBL_W'(1) : '0;
                n_i       = r_i + ADDR_W'(1);
                n_j       = J_W'(2);
                n_tri     = UW'(3);
            end
            srdc_pkg::ST_BUILD_J: begin
                if (j_ext > UW'(eff_n)) begin
                    n_tbl_ready = 1'b1;
                end else if (b_end >= j_ext) begin
                    n_i = ADDR_W'(b_end);
                end else begin
                    n_j   = r_j + J_W'(1);
                    n_tri = r_tri + j_ext + UW'(1);
                end
            end
            srdc_pkg::ST_BUILD_RD_HI: begin
                ram_raddr = r_i;
            end
            srdc_pkg::ST_BUILD_RD_LO: begin
                ram_raddr = r_i - ADDR_W'(r_j);
                n_hi      = ram_rdata;
            end
            srdc_pkg::ST_BUILD_WR: begin
                ram_we    = 1'b1;
                ram_wdata = r_hi + ram_rdata;
                ram_raddr = r_i - ADDR_W'(1);
                n_i       = r_i - ADDR_W'(1);
                if (UW'(r_i) == j_ext) begin
                    n_j   = r_j + J_W'(1);
                    n_tri = r_tri + j_ext + UW'(1);
                end
            end
            srdc_pkg::ST_START: begin
                n_k       = (r_mode == srdc_pkg::MODE_DENSITY) ? UW'(r_rank) : '0;
                n_acc     = '0;
                n_dv      = 1'b0;
                n_res_count = '0;
                n_res_q     = '0;
                if (r_mode == srdc_pkg::MODE_CUMUL) begin
                    n_res_count = COUNT_W'(full);
                end else if (r_mode == srdc_pkg::MODE_QUANTILE) begin
                    n_res_count = COUNT_W'(full);
                    n_res_q     = RANK_W'(u);
                end
            end
            srdc_pkg::ST_WALK: begin
                n_dv = 1'b1;
                n_kd = r_k;
                n_zd = k_zero;
                n_k  = r_k + UW'(1);
                if (r_dv) begin
                    n_acc = acc_sum;
                end
                if (walk_done) begin
                    n_dv        = 1'b0;
                    n_res_count = COUNT_W'(acc_sum);
                    n_res_q     = (r_mode == srdc_pkg::MODE_QUANTILE) ? RANK_W'(r_kd) : '0;
                end
            end
            srdc_pkg::ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_count     = r_res_count;
                    n_quantile  = r_res_q;
                end
            end
            default: begin
                n_dv = 1'b0;
            end
        endcase

        if (cfg_we) begin
            n_sample    = pwdata[srdc_pkg::SAMPLE_W-1:0];
            n_tbl_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srdc_pkg::ST_IDLE;
            r_sample    <= srdc_pkg::SAMPLE_W'(1);
            r_tbl_ready <= 1'b0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sample    <= n_sample;
            r_tbl_ready <= n_tbl_ready;
            r_out_valid <= n_out_valid;
            r_dv        <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_rank      <= n_rank;
        r_thr       <= n_thr;
        r_i         <= n_i;
        r_j         <= n_j;
        r_tri       <= n_tri;
        r_hi        <= n_hi;
        r_k         <= n_k;
        r_kd        <= n_kd;
        r_zd        <= n_zd;
        r_acc       <= n_acc;
        r_res_count <= n_res_count;
        r_res_q     <= n_res_q;
        r_count     <= n_count;
        r_quantile  <= n_quantile;
    end

    `SRDC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_accept, o_in_stall, "input not held off after an item")
    `SRDC_ASSERT_ALWAYS(a_walk_built, i_clk, i_rst_n, r_state != srdc_pkg::ST_WALK || r_tbl_ready, "table read before it was built")
    `SRDC_ASSERT_ALWAYS(a_build_index, i_clk, i_rst_n, r_state != srdc_pkg::ST_BUILD_WR || UW'(r_i) >= j_ext, "knapsack update below the item weight")

endmodule
